// File: sv/zcbrc_pkg.sv
// ----------------------------------------------------------------------------
// zcbrc_pkg
// Shared types and constants of the zero-cross burst relay control block.
// ----------------------------------------------------------------------------
`default_nettype none

package zcbrc_pkg;

   localparam int unsigned COUNT_WIDTH = 5;
   localparam int unsigned DUTY_WIDTH = 6;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned STAT_WIDTH = 32;
   localparam int unsigned DELAY_WIDTH_DEFAULT = 16;

   localparam logic [COUNT_WIDTH-1:0] PERIOD_EDGES = 5'd20;
   localparam logic [COUNT_WIDTH-1:0] RESET_FLIP_POINT = 5'd10;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_DELAY_TICKS = 16'd2000;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_EDGE = 2'd1,
      CMD_DUTY = 2'd2
   } command_type;

   typedef enum logic [0:0] {
      CSR_INITIAL_FLIP = 1'b0,
      CSR_DELAY_TICKS  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// File: sv/zero_cross_burst_relay_control.sv
// ----------------------------------------------------------------------------
// zero_cross_burst_relay_control
// Burst-fire relay control driven by zero-cross edges, microsecond ticks and
// duty requests, with a one-shot delay and period measurement.
//
//   Channel | Direction | Handshake          | Contents
//   req     | in        | req_valid/stall    | command, duty value
//   rsp     | out       | rsp_valid/stall    | relay state and statistics
//   csr     | in        | csr_write          | register index, write data
//
// One transaction is accepted per cycle unless req is stalled; its result
// appears in the next cycle from the result register. The state update is a
// single pass of counters and compares between the state registers and the
// result register. Reset is synchronous and restores the register defaults.
// A stalled result holds the result register and stalls req in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_cross_burst_relay_control #(
   parameter int unsigned DELAY_WIDTH = zcbrc_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_command,
   input  wire logic [zcbrc_pkg::DUTY_WIDTH-1:0]     req_duty_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_relay_level,
   output logic [zcbrc_pkg::COUNT_WIDTH-1:0]         rsp_edge_count,
   output logic [zcbrc_pkg::COUNT_WIDTH-1:0]         rsp_active_flip,
   output logic                                      rsp_update_queued,
   output logic                                      rsp_update_applied,
   output logic                                      rsp_request_rejected,
   output logic [zcbrc_pkg::STAT_WIDTH-1:0]          rsp_period_ticks,
   output logic                                      rsp_period_valid,
   output logic [zcbrc_pkg::STAT_WIDTH-1:0]          rsp_cycle_total,
   output logic [zcbrc_pkg::STAT_WIDTH-1:0]          rsp_trigger_total,
   input  wire logic                                 csr_write,
   input  wire logic [0:0]                           csr_index,
   input  wire logic [zcbrc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   import zcbrc_pkg::*;

   logic                      req_accept;

   logic [CSR_DATA_WIDTH-1:0] delay_ticks_ff, delay_ticks_in;
   logic [COUNT_WIDTH-1:0]    edges_seen_ff, edges_seen_in;
   logic [COUNT_WIDTH-1:0]    flip_now_ff, flip_now_in;
   logic [COUNT_WIDTH-1:0]    flip_queued_ff, flip_queued_in;
   logic                      flip_queued_valid_ff, flip_queued_valid_in;
   logic                      relay_drive_ff, relay_drive_in;
   logic                      scheduled_level_ff, scheduled_level_in;
   logic                      scheduled_valid_ff, scheduled_valid_in;
   logic [DELAY_WIDTH-1:0]    delay_counter_ff, delay_counter_in;
   logic                      delay_running_ff, delay_running_in;
   logic [STAT_WIDTH-1:0]     tick_clock_ff, tick_clock_in;
   logic [STAT_WIDTH-1:0]     last_stamp_ff, last_stamp_in;
   logic                      stamp_seen_ff, stamp_seen_in;
   logic [STAT_WIDTH-1:0]     measured_period_ff, measured_period_in;
   logic                      period_known_ff, period_known_in;
   logic [STAT_WIDTH-1:0]     cycles_done_ff, cycles_done_in;
   logic [STAT_WIDTH-1:0]     triggers_done_ff, triggers_done_in;

   logic                      applied;
   logic                      rejected;
   logic [DELAY_WIDTH-1:0]    delay_target;
   logic [DELAY_WIDTH-1:0]    delay_next;
   logic [COUNT_WIDTH-1:0]    edges_next;
   logic [COUNT_WIDTH-1:0]    flip_next;

   logic                      rsp_valid_ff;
   logic                      out_relay_ff;
   logic [COUNT_WIDTH-1:0]    out_edges_ff;
   logic [COUNT_WIDTH-1:0]    out_flip_ff;
   logic                      out_queued_ff;
   logic                      out_applied_ff;
   logic                      out_rejected_ff;
   logic [STAT_WIDTH-1:0]     out_period_ff;
   logic                      out_period_valid_ff;
   logic [STAT_WIDTH-1:0]     out_cycles_ff;
   logic [STAT_WIDTH-1:0]     out_triggers_ff;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      delay_ticks_in       = delay_ticks_ff;
      edges_seen_in        = edges_seen_ff;
      flip_now_in          = flip_now_ff;
      flip_queued_in       = flip_queued_ff;
      flip_queued_valid_in = flip_queued_valid_ff;
      relay_drive_in       = relay_drive_ff;
      scheduled_level_in   = scheduled_level_ff;
      scheduled_valid_in   = scheduled_valid_ff;
      delay_counter_in     = delay_counter_ff;
      delay_running_in     = delay_running_ff;
      tick_clock_in        = tick_clock_ff;
      last_stamp_in        = last_stamp_ff;
      stamp_seen_in        = stamp_seen_ff;
      measured_period_in   = measured_period_ff;
      period_known_in      = period_known_ff;
      cycles_done_in       = cycles_done_ff;
      triggers_done_in     = triggers_done_ff;
      applied              = 1'b0;
      rejected             = 1'b0;

      delay_target = DELAY_WIDTH'(delay_ticks_ff);
      if (delay_target == '0) begin
         delay_target = DELAY_WIDTH'(1);
      end
      delay_next = delay_counter_ff + DELAY_WIDTH'(1);
      edges_next = edges_seen_ff + COUNT_WIDTH'(1);
      flip_next  = flip_queued_valid_ff ? flip_queued_ff : flip_now_ff;

      if (req_accept) begin
         case (req_command)
            CMD_TICK: begin
               tick_clock_in = tick_clock_ff + STAT_WIDTH'(1);
               if (delay_running_ff) begin
                  delay_counter_in = delay_next;
                  if (delay_next >= delay_target) begin
                     delay_running_in = 1'b0;
                     if (scheduled_valid_ff) begin
                        relay_drive_in     = scheduled_level_ff;
                        scheduled_valid_in = 1'b0;
                     end
                  end
               end
            end
            CMD_EDGE: begin
               edges_seen_in = edges_next;
               if (flip_now_ff != '0 && flip_now_ff < PERIOD_EDGES &&
                   edges_next == flip_now_ff) begin
                  triggers_done_in   = triggers_done_ff + STAT_WIDTH'(1);
                  scheduled_level_in = 1'b0;
                  scheduled_valid_in = 1'b1;
                  delay_counter_in   = '0;
                  delay_running_in   = 1'b1;
               end else if (edges_next >= PERIOD_EDGES) begin
                  triggers_done_in = triggers_done_ff + STAT_WIDTH'(1);
                  if (stamp_seen_ff) begin
                     measured_period_in = tick_clock_ff - last_stamp_ff;
                     period_known_in    = 1'b1;
                  end
                  last_stamp_in        = tick_clock_ff;
                  stamp_seen_in        = 1'b1;
                  cycles_done_in       = cycles_done_ff + STAT_WIDTH'(1);
                  applied              = flip_queued_valid_ff;
                  flip_now_in          = flip_next;
                  flip_queued_valid_in = 1'b0;
                  edges_seen_in        = '0;
                  scheduled_level_in   = (flip_next != '0);
                  scheduled_valid_in   = 1'b1;
                  delay_counter_in     = '0;
                  delay_running_in     = 1'b1;
               end
            end
            CMD_DUTY: begin
               if (req_duty_value > DUTY_WIDTH'(PERIOD_EDGES)) begin
                  rejected = 1'b1;
               end else if (req_duty_value == DUTY_WIDTH'(flip_now_ff)) begin
                  flip_queued_valid_in = 1'b0;
               end else begin
                  flip_queued_in       = req_duty_value[COUNT_WIDTH-1:0];
                  flip_queued_valid_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INITIAL_FLIP: begin
               if (csr_wdata[COUNT_WIDTH-1:0] <= PERIOD_EDGES) begin
                  flip_now_in          = csr_wdata[COUNT_WIDTH-1:0];
                  flip_queued_valid_in = 1'b0;
                  relay_drive_in       = (csr_wdata[COUNT_WIDTH-1:0] != '0);
               end
            end
            CSR_DELAY_TICKS: begin
               delay_ticks_in = csr_wdata;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff       <= RESET_DELAY_TICKS;
         edges_seen_ff        <= '0;
         flip_now_ff          <= RESET_FLIP_POINT;
         flip_queued_ff       <= '0;
         flip_queued_valid_ff <= 1'b0;
         relay_drive_ff       <= (RESET_FLIP_POINT != '0);
         scheduled_level_ff   <= 1'b0;
         scheduled_valid_ff   <= 1'b0;
         delay_counter_ff     <= '0;
         delay_running_ff     <= 1'b0;
         tick_clock_ff        <= '0;
         last_stamp_ff        <= '0;
         stamp_seen_ff        <= 1'b0;
         measured_period_ff   <= '0;
         period_known_ff      <= 1'b0;
         cycles_done_ff       <= '0;
         triggers_done_ff     <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         delay_ticks_ff       <= delay_ticks_in;
         edges_seen_ff        <= edges_seen_in;
         flip_now_ff          <= flip_now_in;
         flip_queued_ff       <= flip_queued_in;
         flip_queued_valid_ff <= flip_queued_valid_in;
         relay_drive_ff       <= relay_drive_in;
         scheduled_level_ff   <= scheduled_level_in;
         scheduled_valid_ff   <= scheduled_valid_in;
         delay_counter_ff     <= delay_counter_in;
         delay_running_ff     <= delay_running_in;
         tick_clock_ff        <= tick_clock_in;
         last_stamp_ff        <= last_stamp_in;
         stamp_seen_ff        <= stamp_seen_in;
         measured_period_ff   <= measured_period_in;
         period_known_ff      <= period_known_in;
         cycles_done_ff       <= cycles_done_in;
         triggers_done_ff     <= triggers_done_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_relay_ff        <= relay_drive_in;
         out_edges_ff        <= edges_seen_in;
         out_flip_ff         <= flip_now_in;
         out_queued_ff       <= flip_queued_valid_in;
         out_applied_ff      <= applied;
         out_rejected_ff     <= rejected;
         out_period_ff       <= measured_period_in;
         out_period_valid_ff <= period_known_in;
         out_cycles_ff       <= cycles_done_in;
         out_triggers_ff     <= triggers_done_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_relay_level      = out_relay_ff;
   assign rsp_edge_count       = out_edges_ff;
   assign rsp_active_flip      = out_flip_ff;
   assign rsp_update_queued    = out_queued_ff;
   assign rsp_update_applied   = out_applied_ff;
   assign rsp_request_rejected = out_rejected_ff;
   assign rsp_period_ticks     = out_period_ff;
   assign rsp_period_valid     = out_period_valid_ff;
   assign rsp_cycle_total      = out_cycles_ff;
   assign rsp_trigger_total    = out_triggers_ff;

endmodule

`default_nettype wire

// File: sv/zcbrc_check.sv
// ----------------------------------------------------------------------------
// zcbrc_check
// Port-level checks of the zero-cross burst relay control block.
// ----------------------------------------------------------------------------
`default_nettype none

module zcbrc_check (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [zcbrc_pkg::COUNT_WIDTH-1:0] rsp_edge_count,
   input wire logic [zcbrc_pkg::COUNT_WIDTH-1:0] rsp_active_flip,
   input wire logic                             rsp_update_queued,
   input wire logic                             rsp_update_applied,
   input wire logic                             rsp_request_rejected,
   input wire logic [zcbrc_pkg::STAT_WIDTH-1:0]  rsp_period_ticks,
   input wire logic                             rsp_period_valid,
   input wire logic [zcbrc_pkg::STAT_WIDTH-1:0]  rsp_trigger_total
);

   import zcbrc_pkg::*;

   // A stalled transaction must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_trigger_total) &&
         $stable(rsp_edge_count))
      else $error("rsp transaction changed while stalled");

   // Counts and flip points never leave the period range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_edge_count < PERIOD_EDGES && rsp_active_flip <= PERIOD_EDGES)
      else $error("edge count or flip point out of range");

   // A queued flip point is only applied at a period boundary, and it leaves
   // nothing queued behind it.
   a_applied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_applied |->
         rsp_edge_count == '0 && !rsp_update_queued && !rsp_request_rejected)
      else $error("flip point applied outside a period boundary");

   // No period is reported before two boundaries have been seen.
   a_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_period_valid |-> rsp_period_ticks == '0)
      else $error("period reported before it is known");

endmodule

bind zero_cross_burst_relay_control zcbrc_check u_zcbrc_check (.*);

`default_nettype wire

// File: verif/zero_cross_burst_relay_control_tb.sv
// ----------------------------------------------------------------------------
// zero_cross_burst_relay_control_tb
// Self-checking testbench for the zero-cross burst relay control block.
//
// A relay status scoreboard keeps its own copy of the control state: edge
// counting, flip point queueing, the one-shot level delay and the period
// statistics. It predicts one status for every accepted request transaction.
// Each returned status is compared field by field against the oldest
// prediction. A directed sequence covers rejected, duplicate and unused
// requests and a restarted delay. Random phases then run under several
// register settings, including the longest delay setting. Both sides insert
// random idle bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_cross_burst_relay_control_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import zcbrc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int SHOWN_LINES = 40;

   typedef struct packed {
      logic        relay_level;
      logic [4:0]  edge_count;
      logic [4:0]  active_flip;
      logic        update_queued;
      logic        update_applied;
      logic        request_rejected;
      logic [31:0] period_ticks;
      logic        period_valid;
      logic [31:0] cycle_total;
      logic [31:0] trigger_total;
   } relay_status_type;

   class relay_scoreboard;
      relay_status_type pending_status[$];
      int            mismatch_count;
      int            lines_shown;

      logic [15:0]   delay_setting;
      logic [4:0]    edges_seen;
      logic [4:0]    flip_now;
      logic [4:0]    flip_queued;
      logic          flip_queued_valid;
      logic          relay_on;
      logic          next_level;
      logic          level_pending;
      logic [15:0]   delay_count;
      logic          delay_busy;
      logic [31:0]   tick_clock;
      logic [31:0]   boundary_stamp;
      logic          stamp_valid;
      logic [31:0]   period_measured;
      logic          period_known;
      logic [31:0]   cycle_count;
      logic [31:0]   trigger_count;

      function new();
         mismatch_count    = 0;
         lines_shown       = 0;
         delay_setting     = RESET_DELAY_TICKS;
         edges_seen        = '0;
         flip_now          = RESET_FLIP_POINT;
         flip_queued       = '0;
         flip_queued_valid = 1'b0;
         relay_on          = (RESET_FLIP_POINT != 0);
         next_level        = 1'b0;
         level_pending     = 1'b0;
         delay_count       = '0;
         delay_busy        = 1'b0;
         tick_clock        = '0;
         boundary_stamp    = '0;
         stamp_valid       = 1'b0;
         period_measured   = '0;
         period_known      = 1'b0;
         cycle_count       = '0;
         trigger_count     = '0;
      endfunction

      function void write_register(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_INITIAL_FLIP: begin
               if (data[4:0] <= PERIOD_EDGES) begin
                  flip_now          = data[4:0];
                  flip_queued_valid = 1'b0;
                  relay_on          = (data[4:0] != 0);
               end
            end
            CSR_DELAY_TICKS: begin
               delay_setting = data;
            end
            default: ;
         endcase
      endfunction

      function void arm_delay(logic level);
         next_level    = level;
         level_pending = 1'b1;
         delay_count   = '0;
         delay_busy    = 1'b1;
      endfunction

      function void note_request(logic [1:0] cmd, logic [5:0] duty);
         relay_status_type want;
         logic [15:0]   target;
         want = '0;
         case (cmd)
            CMD_TICK: begin
               tick_clock = tick_clock + 32'd1;
               if (delay_busy) begin
                  target      = (delay_setting == 0) ? 16'd1 : delay_setting;
                  delay_count = delay_count + 16'd1;
                  if (delay_count >= target) begin
                     delay_busy = 1'b0;
                     if (level_pending) begin
                        relay_on      = next_level;
                        level_pending = 1'b0;
                     end
                  end
               end
            end
            CMD_EDGE: begin
               edges_seen = edges_seen + 5'd1;
               if (flip_now != 0 && flip_now < PERIOD_EDGES && edges_seen == flip_now) begin
                  trigger_count = trigger_count + 32'd1;
                  arm_delay(1'b0);
               end else if (edges_seen >= PERIOD_EDGES) begin
                  trigger_count = trigger_count + 32'd1;
                  if (stamp_valid) begin
                     period_measured = tick_clock - boundary_stamp;
                     period_known    = 1'b1;
                  end
                  boundary_stamp = tick_clock;
                  stamp_valid    = 1'b1;
                  cycle_count    = cycle_count + 32'd1;
                  if (flip_queued_valid) begin
                     flip_now            = flip_queued;
                     flip_queued_valid   = 1'b0;
                     want.update_applied = 1'b1;
                  end
                  edges_seen = '0;
                  arm_delay(flip_now != 0);
               end
            end
            CMD_DUTY: begin
               if (duty > PERIOD_EDGES) begin
                  want.request_rejected = 1'b1;
               end else if (duty == flip_now) begin
                  flip_queued_valid = 1'b0;
               end else begin
                  flip_queued       = duty[4:0];
                  flip_queued_valid = 1'b1;
               end
            end
            default: ;
         endcase
         want.relay_level   = relay_on;
         want.edge_count    = edges_seen;
         want.active_flip   = flip_now;
         want.update_queued = flip_queued_valid;
         want.period_ticks  = period_known ? period_measured : 32'd0;
         want.period_valid  = period_known;
         want.cycle_total   = cycle_count;
         want.trigger_total = trigger_count;
         pending_status.push_back(want);
      endfunction

      task note_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatch_count++;
         if (lines_shown < SHOWN_LINES) begin
            lines_shown++;
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
         end
      endtask

      task compare_field(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) note_mismatch(what, got, want);
      endtask

      task check_status(relay_status_type got);
         relay_status_type want;
         if (pending_status.size() == 0) begin
            note_mismatch("unexpected status transaction", 32'd0, 32'd0);
         end else begin
            want = pending_status.pop_front();
            compare_field("relay_level", 32'(got.relay_level), 32'(want.relay_level));
            compare_field("edge_count", 32'(got.edge_count), 32'(want.edge_count));
            compare_field("active_flip", 32'(got.active_flip), 32'(want.active_flip));
            compare_field("update_queued", 32'(got.update_queued),
                          32'(want.update_queued));
            compare_field("update_applied", 32'(got.update_applied),
                          32'(want.update_applied));
            compare_field("request_rejected", 32'(got.request_rejected),
                          32'(want.request_rejected));
            compare_field("period_ticks", got.period_ticks, want.period_ticks);
            compare_field("period_valid", 32'(got.period_valid), 32'(want.period_valid));
            compare_field("cycle_total", got.cycle_total, want.cycle_total);
            compare_field("trigger_total", got.trigger_total, want.trigger_total);
         end
      endtask

      function int outstanding();
         return pending_status.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_TICK;
   logic [5:0]  req_duty_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_relay_level;
   logic [4:0]  rsp_edge_count;
   logic [4:0]  rsp_active_flip;
   logic        rsp_update_queued;
   logic        rsp_update_applied;
   logic        rsp_request_rejected;
   logic [31:0] rsp_period_ticks;
   logic        rsp_period_valid;
   logic [31:0] rsp_cycle_total;
   logic [31:0] rsp_trigger_total;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = CSR_INITIAL_FLIP;
   logic [15:0] csr_wdata = '0;

   relay_scoreboard sb;
   bit          req_gaps = 1'b0;
   bit          rsp_gaps = 1'b0;
   int          stall_left = 0;
   int          cycle_count = 0;
   relay_status_type seen;

   zero_cross_burst_relay_control u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_duty_value       (req_duty_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_relay_level      (rsp_relay_level),
      .rsp_edge_count       (rsp_edge_count),
      .rsp_active_flip      (rsp_active_flip),
      .rsp_update_queued    (rsp_update_queued),
      .rsp_update_applied   (rsp_update_applied),
      .rsp_request_rejected (rsp_request_rejected),
      .rsp_period_ticks     (rsp_period_ticks),
      .rsp_period_valid     (rsp_period_valid),
      .rsp_cycle_total      (rsp_cycle_total),
      .rsp_trigger_total    (rsp_trigger_total),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("zero_cross_burst_relay_control test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_gaps && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 11) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.relay_level      = rsp_relay_level;
         seen.edge_count       = rsp_edge_count;
         seen.active_flip      = rsp_active_flip;
         seen.update_queued    = rsp_update_queued;
         seen.update_applied   = rsp_update_applied;
         seen.request_rejected = rsp_request_rejected;
         seen.period_ticks     = rsp_period_ticks;
         seen.period_valid     = rsp_period_valid;
         seen.cycle_total      = rsp_cycle_total;
         seen.trigger_total    = rsp_trigger_total;
         sb.check_status(seen);
      end
   end

   task send_request(logic [1:0] cmd, logic [5:0] duty);
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_duty_value <= duty;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, duty);
   endtask

   task drain_status;
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task write_csr(csr_index_type idx, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task run_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_request(CMD_TICK, 6'($urandom_range(0, 63)));
         end else if (pick < 85) begin
            send_request(CMD_EDGE, 6'($urandom_range(0, 63)));
         end else if (pick < 95) begin
            send_request(CMD_DUTY, 6'($urandom_range(0, 20)));
         end else if (pick < 98) begin
            send_request(CMD_DUTY, 6'($urandom_range(21, 63)));
         end else begin
            send_request(CMD_UNUSED, 6'($urandom_range(0, 63)));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: flip point 10 arms the delay, and the boundary restarts it.
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      send_request(CMD_DUTY, 6'd63);
      send_request(CMD_DUTY, 6'd21);
      send_request(CMD_UNUSED, 6'd42);
      send_request(CMD_DUTY, 6'd20);
      send_request(CMD_DUTY, 6'd10);
      send_request(CMD_DUTY, 6'd0);
      send_request(CMD_TICK, 6'd0);
      repeat (20) send_request(CMD_EDGE, 6'($urandom_range(0, 63)));

      drain_status();
      write_csr(CSR_INITIAL_FLIP, 16'd0);
      write_csr(CSR_DELAY_TICKS, 16'd0);
      csr_write <= 1'b0;
      run_random(220);

      drain_status();
      req_gaps = 1'b1;
      rsp_gaps = 1'b0;
      write_csr(CSR_INITIAL_FLIP, 16'd20);
      write_csr(CSR_DELAY_TICKS, 16'd1);
      csr_write <= 1'b0;
      run_random(220);

      // Longest delay setting; the delay is still running when this phase ends.
      drain_status();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      write_csr(CSR_INITIAL_FLIP, 16'd7);
      write_csr(CSR_DELAY_TICKS, 16'hFFFF);
      csr_write <= 1'b0;
      repeat (20) send_request(CMD_EDGE, 6'($urandom_range(0, 63)));
      repeat (40) send_request(CMD_TICK, 6'($urandom_range(0, 63)));

      drain_status();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      write_csr(CSR_INITIAL_FLIP, 16'hFFF5);
      write_csr(CSR_INITIAL_FLIP, 16'hFFE3);
      write_csr(CSR_INITIAL_FLIP, 16'h001F);
      write_csr(CSR_DELAY_TICKS, 16'd3);
      csr_write <= 1'b0;
      run_random(200);

      drain_status();
      req_gaps = 1'b0;
      rsp_gaps = 1'b1;
      write_csr(CSR_INITIAL_FLIP, 16'd19);
      write_csr(CSR_DELAY_TICKS, 16'd2);
      csr_write <= 1'b0;
      run_random(220);

      drain_status();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      write_csr(CSR_INITIAL_FLIP, 16'($urandom_range(1, 18)));
      write_csr(CSR_DELAY_TICKS, 16'($urandom_range(1, 6)));
      csr_write <= 1'b0;
      run_random(220);

      drain_status();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      write_csr(CSR_INITIAL_FLIP, 16'd13);
      write_csr(CSR_DELAY_TICKS, 16'd4);
      csr_write <= 1'b0;
      run_random(150);

      drain_status();
      repeat (4) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("zero_cross_burst_relay_control test passed");
      end else begin
         $display("zero_cross_burst_relay_control test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
sv/zcbrc_pkg.sv
sv/zero_cross_burst_relay_control.sv
sv/zcbrc_check.sv
verif/zero_cross_burst_relay_control_tb.sv
